// File: rtl/core/lct_pkg.sv
// Shared types and constants for the LRU cache table.
package lct_pkg;

	localparam int KEY_PORT_W = 32;
	localparam int VAL_PORT_W = 32;
	localparam int LIMIT_W    = 5;
	localparam int COUNT_W    = 5;
	localparam int ACTION_W   = 2;

	typedef logic [ACTION_W-1:0] action_t;

	localparam action_t ACT_PUT  = 2'd0;
	localparam action_t ACT_FIND = 2'd1;
	localparam action_t ACT_TAKE = 2'd2;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

endpackage

// File: rtl/core/lru_cache_table_unit.sv
// Fully associative key/value table kept in recency order (top level).
//
// Request channel: req_valid / req_stall with action, key, value. A request
// transfers at a clock edge where req_valid is high and req_stall is low.
// Response channel: rsp_valid / rsp_stall with hit, value_out, evicted,
// evicted_key, mru_valid, mru_value and entry_count; one response per request.
// Configuration: entry_limit is written when cfg_valid is high (cfg_ready is
// always high); write it only while no request is in flight.
// One request is taken every cycle while the receiver does not stall: the
// request register feeds a parallel key compare over all entries, the
// recency rank update and the eviction pick, and the whole table update
// lands in the same edge that loads the response register (rsp_valid).
// When the receiver stalls, the response register holds; the request register
// still takes one more request, then req_stall rises until the response moves.
// Reset clears all valid bits, ranks and the entry count, and sets the limit
// to 16 (clamped to CAPACITY). Key and value storage is not cleared.
module lru_cache_table_unit
	import lct_pkg::*;
#(
	parameter int CAPACITY   = 16,
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [LIMIT_W-1:0]    entry_limit,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  logic [ACTION_W-1:0]   action,
	input  logic [KEY_PORT_W-1:0] key,
	input  logic [VAL_PORT_W-1:0] value,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output logic                  hit,
	output logic [VAL_PORT_W-1:0] value_out,
	output logic                  evicted,
	output logic [KEY_PORT_W-1:0] evicted_key,
	output logic                  mru_valid,
	output logic [VAL_PORT_W-1:0] mru_value,
	output logic [COUNT_W-1:0]    entry_count
);

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int KW = (KEY_BITS < KEY_PORT_W) ? KEY_BITS : KEY_PORT_W;
	localparam int VW = (VALUE_BITS < VAL_PORT_W) ? VALUE_BITS : VAL_PORT_W;
	localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;

	typedef logic [CAPACITY-1:0] vec_t;

	// table state
	vec_t                vld_q;
	logic [IW-1:0]       rank_q [CAPACITY];
	logic [KW-1:0]       key_q  [CAPACITY];
	logic [VW-1:0]       val_q  [CAPACITY];
	logic [CW-1:0]       cnt_q;
	logic [LIMIT_W-1:0]  lim_q;
	logic [VW-1:0]       mru_q;

	// request stage
	logic                vld_s1;
	action_t             act_s1;
	logic [KW-1:0]       key_s1;
	logic [VW-1:0]       val_s1;

	// response stage
	logic                vld_s2;
	logic                hit_s2;
	logic [VW-1:0]       vout_s2;
	logic                ev_s2;
	logic [KW-1:0]       evk_s2;
	logic                mruv_s2;
	logic [VW-1:0]       mru_s2;
	logic [CW-1:0]       cnt_s2;

	logic adv, fire;

	assign adv       = !vld_s2 || !rsp_stall;
	assign fire      = vld_s1 && adv;
	assign req_stall = vld_s1 && !adv;
	assign cfg_ready = 1'b1;

	// effective limit, clamped to 1..CAPACITY
	logic [LW-1:0] lim_x, lim_c;
	logic [CW-1:0] lim_eff;

	always_comb begin
		lim_x = LW'(lim_q);
		if (lim_x == '0) begin
			lim_c = LW'(1);
		end else if (lim_x > LW'(CAPACITY)) begin
			lim_c = LW'(CAPACITY);
		end else begin
			lim_c = lim_x;
		end
		lim_eff = CW'(lim_c);
	end

	logic [IW-1:0] held_m1;
	logic          full;
	logic          is_put, is_find, is_take;
	vec_t          mvec, m_oh, lvec, free_oh, tvec, evv, slot, ins_vec, sel_vec, wr_val;
	logic          m_hit, do_ins, ev_any, hit_n;
	logic [IW-1:0] r_t;
	logic [IW-1:0] rank_a [CAPACITY];
	logic [IW-1:0] rank_n [CAPACITY];
	vec_t          vld_n;
	logic [CW-1:0] cnt_n;
	logic [KW-1:0] evk_n;
	logic [VW-1:0] vout_n, mru_n;

	assign held_m1 = IW'(cnt_q - CW'(1));
	assign full    = (cnt_q == CW'(CAPACITY));
	assign is_put  = (act_s1 == ACT_PUT);
	assign is_find = (act_s1 == ACT_FIND);
	assign is_take = (act_s1 == ACT_TAKE);

	// parallel compare against every entry
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			mvec[i] = vld_q[i] && (key_q[i] == key_s1);
			lvec[i] = vld_q[i] && (rank_q[i] == held_m1);
		end
	end

	assign m_oh    = mvec & (~mvec + vec_t'(1));
	assign free_oh = ~vld_q & (vld_q + vec_t'(1));
	assign m_hit   = |mvec;
	assign do_ins  = is_put && !m_hit;

	always_comb begin
		case (act_s1)
			ACT_PUT:  tvec = m_oh;
			ACT_FIND: tvec = m_oh;
			ACT_TAKE: tvec = lvec;
			default:  tvec = '0;
		endcase
	end

	// rank of the touched entry
	always_comb begin
		r_t = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			r_t = r_t | (tvec[i] ? rank_q[i] : '0);
		end
	end

	// ranks after touch or insert, before eviction
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			if (!vld_q[i]) begin
				rank_a[i] = rank_q[i];
			end else if (do_ins) begin
				rank_a[i] = rank_q[i] + IW'(1);
			end else if (tvec[i]) begin
				rank_a[i] = '0;
			end else if (rank_q[i] < r_t) begin
				rank_a[i] = rank_q[i] + IW'(1);
			end else begin
				rank_a[i] = rank_q[i];
			end
		end
	end

	// eviction pick: a replacing put over the limit evicts the entry that is least recent
	// after the touch; a new key at or over the limit evicts the old least recent entry
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			if (is_put && m_hit && (cnt_q > lim_eff)) begin
				evv[i] = vld_q[i] && (rank_a[i] == held_m1);
			end else if (do_ins && (cnt_q >= lim_eff)) begin
				evv[i] = lvec[i];
			end else begin
				evv[i] = 1'b0;
			end
		end
	end

	assign ev_any  = |evv;
	assign slot    = full ? lvec : free_oh;
	assign ins_vec = do_ins ? slot : '0;
	assign wr_val  = ins_vec | (is_put ? m_oh : '0);
	assign sel_vec = is_find ? m_oh : (is_take ? lvec : '0);
	assign hit_n   = |sel_vec;

	always_comb begin
		evk_n  = '0;
		vout_n = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			evk_n    = evk_n | (evv[i] ? key_q[i] : '0);
			vout_n   = vout_n | (sel_vec[i] ? val_q[i] : '0);
			vld_n[i] = (vld_q[i] && !evv[i]) || ins_vec[i];
			rank_n[i] = (ins_vec[i] || evv[i]) ? '0 : rank_a[i];
		end
	end

	assign cnt_n = cnt_q + CW'(do_ins) - CW'(ev_any);
	assign mru_n = is_put ? val_s1 : (hit_n ? vout_n : mru_q);

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q <= LIMIT_RESET;
		end else if (cfg_valid) begin
			lim_q <= entry_limit;
		end
	end

	// request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!req_stall) begin
			vld_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			act_s1 <= action;
			key_s1 <= key[KW-1:0];
			val_s1 <= value[VW-1:0];
		end
	end

	// table control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			cnt_q <= '0;
			for (int i = 0; i < CAPACITY; i++) begin
				rank_q[i] <= '0;
			end
		end else if (fire) begin
			vld_q <= vld_n;
			cnt_q <= cnt_n;
			for (int i = 0; i < CAPACITY; i++) begin
				rank_q[i] <= rank_n[i];
			end
		end
	end

	// key and value storage
	always_ff @(posedge clk) begin
		if (fire) begin
			mru_q <= mru_n;
			for (int i = 0; i < CAPACITY; i++) begin
				if (ins_vec[i]) begin
					key_q[i] <= key_s1;
				end
				if (wr_val[i]) begin
					val_q[i] <= val_s1;
				end
			end
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			hit_s2  <= hit_n;
			vout_s2 <= vout_n;
			ev_s2   <= ev_any;
			evk_s2  <= evk_n;
			mruv_s2 <= (cnt_n != '0);
			mru_s2  <= (cnt_n != '0) ? mru_n : '0;
			cnt_s2  <= cnt_n;
		end
	end

	logic [31:0] cnt_wide;
	assign cnt_wide = 32'(cnt_s2);

	assign rsp_valid   = vld_s2;
	assign hit         = hit_s2;
	assign value_out   = VAL_PORT_W'(vout_s2);
	assign evicted     = ev_s2;
	assign evicted_key = KEY_PORT_W'(evk_s2);
	assign mru_valid   = mruv_s2;
	assign mru_value   = VAL_PORT_W'(mru_s2);
	assign entry_count = cnt_wide[COUNT_W-1:0];

	// checks
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_cnt_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(vld_q) == int'(cnt_q))
		else $error("entry count differs from valid bits");

	a_put_leaves_mru: assert property (@(posedge clk) disable iff (!arst_n)
		fire && is_put |=> rsp_valid && mru_valid && (cnt_q != '0))
		else $error("put left the table empty");

	a_evict_only_on_put: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !is_put |=> !evicted)
		else $error("eviction outside a put");

endmodule

// File: tb/lct_check_pkg.sv
// Recency-table predictor and reply checker for the LRU cache table bench.
package lct_check_pkg;
	import lct_pkg::*;

	localparam int      SLOTS   = 16;
	localparam action_t ACT_NOP = 2'd3;

	typedef struct {
		logic                  hit;
		logic [VAL_PORT_W-1:0] value_out;
		logic                  evicted;
		logic [KEY_PORT_W-1:0] evicted_key;
		logic                  mru_valid;
		logic [VAL_PORT_W-1:0] mru_value;
		logic [COUNT_W-1:0]    entry_count;
	} table_reply_t;

	class lru_table_tracker;
		logic [KEY_PORT_W-1:0] slot_key[SLOTS];
		logic [VAL_PORT_W-1:0] slot_val[SLOTS];
		bit                    slot_used[SLOTS];
		int unsigned           slot_rank[SLOTS];
		int unsigned           held;
		logic [LIMIT_W-1:0]    limit;
		table_reply_t          replies_due[$];
		int unsigned           errors;
		int unsigned           per_action[4];
		int unsigned           hits;
		int unsigned           evictions;
		int unsigned           peak;

		function new();
			held   = 0;
			limit  = LIMIT_RESET;
			errors = 0;
			hits   = 0;
			evictions = 0;
			peak   = 0;
			foreach (slot_used[i]) begin
				slot_used[i] = 1'b0;
				slot_rank[i] = 0;
				per_action[i % 4] = 0;
			end
		endfunction

		function int pending();
			return replies_due.size();
		endfunction

		// lowest valid slot holding this key
		function int match_slot(logic [KEY_PORT_W-1:0] k);
			for (int i = 0; i < SLOTS; i++)
				if (slot_used[i] && slot_key[i] == k) return i;
			return -1;
		endfunction

		function int rank_slot(int unsigned r);
			for (int i = 0; i < SLOTS; i++)
				if (slot_used[i] && slot_rank[i] == r) return i;
			return -1;
		endfunction

		function int oldest_slot();
			if (held == 0) return -1;
			return rank_slot(held - 1);
		endfunction

		function void promote(int e);
			int unsigned r;
			r = slot_rank[e];
			for (int i = 0; i < SLOTS; i++)
				if (slot_used[i] && slot_rank[i] < r) slot_rank[i]++;
			slot_rank[e] = 0;
		endfunction

		function logic [KEY_PORT_W-1:0] drop_oldest();
			int e;
			e = oldest_slot();
			if (e < 0) return '0;
			slot_used[e] = 1'b0;
			slot_rank[e] = 0;
			held--;
			return slot_key[e];
		endfunction

		// apply one request to the table copy and queue the reply it produces
		function void take_request(action_t a, logic [KEY_PORT_W-1:0] k,
				logic [VAL_PORT_W-1:0] v);
			table_reply_t r;
			int unsigned  cap;
			int           e;
			r = '{default: '0};
			cap = (limit == 0) ? 1 : (limit > SLOTS) ? SLOTS : limit;
			per_action[a]++;
			case (a)
			ACT_PUT: begin
				e = match_slot(k);
				if (e >= 0) begin
					slot_val[e] = v;
					promote(e);
				end else begin
					// full table: make room before inserting
					if (held >= SLOTS) begin
						r.evicted_key = drop_oldest();
						r.evicted     = 1'b1;
					end
					e = -1;
					for (int i = 0; i < SLOTS && e < 0; i++)
						if (!slot_used[i]) e = i;
					for (int i = 0; i < SLOTS; i++)
						if (slot_used[i]) slot_rank[i]++;
					slot_key[e]  = k;
					slot_val[e]  = v;
					slot_used[e] = 1'b1;
					slot_rank[e] = 0;
					held++;
				end
				if (!r.evicted && held > cap) begin
					r.evicted_key = drop_oldest();
					r.evicted     = 1'b1;
				end
			end
			ACT_FIND: begin
				e = match_slot(k);
				if (e >= 0) begin
					r.hit       = 1'b1;
					r.value_out = slot_val[e];
					promote(e);
				end
			end
			ACT_TAKE: begin
				e = oldest_slot();
				if (e >= 0) begin
					r.hit       = 1'b1;
					r.value_out = slot_val[e];
					promote(e);
				end
			end
			default: ;
			endcase
			e = rank_slot(0);
			if (e >= 0) begin
				r.mru_valid = 1'b1;
				r.mru_value = slot_val[e];
			end
			r.entry_count = COUNT_W'(held);
			hits      += r.hit;
			evictions += r.evicted;
			if (held > peak) peak = held;
			replies_due.push_back(r);
		endfunction

		function void compare_field(string field, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, got %0h", field, want, got);
				errors++;
			end
		endfunction

		function void check_reply(table_reply_t got);
			table_reply_t want;
			if (replies_due.size() == 0) begin
				$error("reply transfer with no request outstanding");
				errors++;
				return;
			end
			want = replies_due.pop_front();
			compare_field("hit", 32'(want.hit), 32'(got.hit));
			compare_field("value_out", 32'(want.value_out), 32'(got.value_out));
			compare_field("evicted", 32'(want.evicted), 32'(got.evicted));
			compare_field("evicted_key", 32'(want.evicted_key), 32'(got.evicted_key));
			compare_field("mru_valid", 32'(want.mru_valid), 32'(got.mru_valid));
			compare_field("mru_value", 32'(want.mru_value), 32'(got.mru_value));
			compare_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
		endfunction
	endclass

endpackage

// File: tb/testbench.sv
// Top of the LRU cache table bench: clock, reset, request and reply drivers.
module testbench;
	import lct_pkg::*;
	import lct_check_pkg::*;

	localparam int QUIET_LIMIT = 1000;
	localparam int PHASE_ITEMS = 68;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [LIMIT_W-1:0]    entry_limit;
	logic                  req_valid;
	logic                  req_stall;
	action_t               action;
	logic [KEY_PORT_W-1:0] key;
	logic [VAL_PORT_W-1:0] value;
	logic                  rsp_valid;
	logic                  rsp_stall;
	logic                  hit;
	logic [VAL_PORT_W-1:0] value_out;
	logic                  evicted;
	logic [KEY_PORT_W-1:0] evicted_key;
	logic                  mru_valid;
	logic [VAL_PORT_W-1:0] mru_value;
	logic [COUNT_W-1:0]    entry_count;

	lru_table_tracker      tracker = new();
	bit                    idling;
	bit                    hold_rsp;
	int                    quiet_cycles;
	int unsigned           limit_writes;
	logic [KEY_PORT_W-1:0] key_pool[32];
	int unsigned           pool_size;

	lru_cache_table_unit u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.entry_limit (entry_limit),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.action      (action),
		.key         (key),
		.value       (value),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.hit         (hit),
		.value_out   (value_out),
		.evicted     (evicted),
		.evicted_key (evicted_key),
		.mru_valid   (mru_valid),
		.mru_value   (mru_value),
		.entry_count (entry_count)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	task automatic send_request(action_t a, logic [KEY_PORT_W-1:0] k,
			logic [VAL_PORT_W-1:0] v);
		int unsigned gap;
		gap = idling ? $urandom_range(0, 7) : 0;
		repeat (gap) begin
			@(negedge clk);
			req_valid <= 1'b0;
		end
		@(negedge clk);
		req_valid <= 1'b1;
		action    <= a;
		key       <= k;
		value     <= v;
		do @(posedge clk); while (req_stall);
		tracker.take_request(a, k, v);
	endtask

	// stop offering and wait for every outstanding reply
	task automatic drain_replies();
		@(negedge clk);
		req_valid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
	endtask

	task automatic write_limit(logic [LIMIT_W-1:0] lim);
		@(negedge clk);
		cfg_valid   <= 1'b1;
		entry_limit <= lim;
		do @(posedge clk); while (!cfg_ready);
		tracker.limit = lim;
		limit_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// reply side: random stall per reply, one long hold when asked
	initial begin : reply_side
		int unsigned  wait_n;
		table_reply_t got;
		@(posedge arst_n);
		forever begin
			wait_n = hold_rsp ? 60 : idling ? $urandom_range(0, 7) : 0;
			hold_rsp = 1'b0;
			if (wait_n != 0) begin
				@(negedge clk);
				rsp_stall <= 1'b1;
				repeat (wait_n - 1) @(negedge clk);
			end
			@(negedge clk);
			rsp_stall <= 1'b0;
			do @(posedge clk); while (!rsp_valid);
			got.hit         = hit;
			got.value_out   = value_out;
			got.evicted     = evicted;
			got.evicted_key = evicted_key;
			got.mru_valid   = mru_valid;
			got.mru_value   = mru_value;
			got.entry_count = entry_count;
			tracker.check_reply(got);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("lru_cache_table_unit test failed");
			$finish;
		end
	end

	initial begin
		logic [LIMIT_W-1:0]    lim;
		int unsigned           roll;
		int unsigned           cap;
		action_t               a;
		logic [KEY_PORT_W-1:0] k;
		arst_n       = 1'b0;
		cfg_valid    = 1'b0;
		entry_limit  = LIMIT_RESET;
		req_valid    = 1'b0;
		action       = ACT_PUT;
		key          = '0;
		value        = '0;
		rsp_stall    = 1'b0;
		idling       = 1'b1;
		hold_rsp     = 1'b0;
		quiet_cycles = 0;
		limit_writes = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty table, then field extremes at the reset limit
		send_request(ACT_TAKE, 32'h0, 32'h0);
		send_request(ACT_FIND, 32'h0, 32'hFFFF_FFFF);
		send_request(ACT_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(ACT_PUT, 32'h0, 32'h0);
		send_request(ACT_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(ACT_FIND, 32'h0, 32'h0);
		send_request(ACT_FIND, 32'hFFFF_FFFF, 32'h0);
		send_request(ACT_FIND, 32'h1234_5678, 32'h0);
		send_request(ACT_PUT, 32'h0, 32'h5A5A_5A5A);
		send_request(ACT_TAKE, 32'h0, 32'h0);
		send_request(ACT_NOP, 32'h0, 32'h0);
		drain_replies();

		// limit under the count: one eviction per put, count stays above the limit
		write_limit(5'd1);
		send_request(ACT_PUT, 32'hA5A5_A5A5, 32'h3C3C_3C3C);
		send_request(ACT_PUT, 32'h0, 32'h0000_0001);
		send_request(ACT_FIND, 32'hFFFF_FFFF, 32'h0);
		send_request(ACT_TAKE, 32'h0, 32'h0);
		drain_replies();

		// zero limit behaves as one
		write_limit(5'd0);
		send_request(ACT_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
		send_request(ACT_FIND, 32'h8000_0000, 32'h0);
		drain_replies();

		write_limit(5'd2);
		send_request(ACT_PUT, 32'h1, 32'h11);
		send_request(ACT_PUT, 32'h2, 32'h22);
		send_request(ACT_PUT, 32'h3, 32'h33);
		send_request(ACT_TAKE, 32'h0, 32'h0);

		for (int ph = 0; ph < 10; ph++) begin
			drain_replies();
			case (ph)
			0: lim = 5'd31;
			1: lim = 5'd1;
			2: lim = 5'd0;
			3: lim = 5'd16;
			4: lim = 5'd2;
			default: lim = LIMIT_W'($urandom_range(0, 31));
			endcase
			write_limit(lim);
			cap = (lim == 0) ? 1 : (lim > SLOTS) ? SLOTS : lim;
			// key pool a bit larger than the limit: hits and evictions both happen
			pool_size = cap + $urandom_range(1, 8);
			for (int i = 0; i < pool_size; i++) key_pool[i] = $urandom();
			idling = (ph != 3 && ph != 7);
			if (ph == 5) hold_rsp = 1'b1;
			repeat (PHASE_ITEMS) begin
				roll = $urandom_range(0, 99);
				a = (roll < 45) ? ACT_PUT : (roll < 75) ? ACT_FIND :
					(roll < 96) ? ACT_TAKE : ACT_NOP;
				k = ($urandom_range(0, 99) < 85) ?
					key_pool[$urandom_range(0, pool_size - 1)] : $urandom();
				send_request(a, k, $urandom());
			end
		end

		drain_replies();
		repeat (8) @(posedge clk);
		$display("Exercised %0d puts, %0d finds, %0d takes, %0d unused-code requests, %0d limit writes",
			tracker.per_action[ACT_PUT], tracker.per_action[ACT_FIND],
			tracker.per_action[ACT_TAKE], tracker.per_action[ACT_NOP], limit_writes);
		$display("Saw %0d hits and %0d evictions, table held up to %0d entries",
			tracker.hits, tracker.evictions, tracker.peak);
		if (tracker.errors == 0 && tracker.pending() == 0) begin
			$display("lru_cache_table_unit test passed");
		end else begin
			$display("lru_cache_table_unit test failed");
		end
		$finish;
	end

endmodule

// File: filelist.f
rtl/core/lct_pkg.sv
rtl/core/lru_cache_table_unit.sv
tb/lct_check_pkg.sv
tb/testbench.sv
